/* rtl/csfw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csfw_pkg
// Shared operation codes, status codes and control types for the counting
// semaphore with its first-in first-out wait queue.
// ----------------------------------------------------------------------------
package csfw_pkg;

    // Operation codes carried by the func field of an input word.
    localparam logic [1:0] FN_TRY     = 2'd0;
    localparam logic [1:0] FN_WAIT    = 2'd1;
    localparam logic [1:0] FN_RELEASE = 2'd2;
    localparam logic [1:0] FN_CHECK   = 2'd3;

    // Width of the unit counter and of the max_count register.
    localparam int unsigned COUNT_W = 8;

    // Register data width on the configuration port.
    localparam int unsigned PDATA_W = 32;
    localparam int unsigned PADDR_W = 2;

    // Result status codes.
    typedef enum logic [3:0] {
        ST_ACQUIRED   = 4'd0,
        ST_REFUSED    = 4'd1,
        ST_QUEUED     = 4'd2,
        ST_RELEASED   = 4'd3,
        ST_HANDED     = 4'd4,
        ST_QFULL      = 4'd5,
        ST_UNDERFLOW  = 4'd6,
        ST_CHECK_OK   = 4'd7,
        ST_CHECK_FAIL = 4'd8
    } status_t;

    // Outcome of one operation, passed from the control unit to the output stage.
    typedef struct packed {
        status_t              status;
        logic                 wake_valid;
        logic [COUNT_W-1:0]   count_now;
    } csfw_result_t;

endpackage

/* rtl/counting_semaphore_fifo_waiters.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters
// Counting semaphore with a first-in first-out queue of waiting tasks.
// ----------------------------------------------------------------------------
// Usage:
// An input word (func, task_id) arrives on in_valid/in_ready. Each word
// gives exactly one result word (status, wake_valid, wake_task, count_now,
// waiters_now) on out_valid/out_ready, in order.
// A word's result is registered at the edge that accepts it. Throughput
// is one word per cycle while out_ready is high, set by the single
// read-modify-write of the count and queue pointers; the queue memory read
// for a hand-over happens in the same cycle as that update. The output
// register is the only buffer: while a result waits and out_ready is low,
// in_ready is low; when out_ready is high a new word is taken in the same
// cycle the old result leaves. The max_count register sits at address 0 of
// the APB port; the user must write it only while the block is idle, which
// the block does not enforce. Reset sets max_count to 1 and clears the
// count and queue pointers; the queue memory needs no clearing pass.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_waiters #(
    parameter int unsigned MAX_WAITERS  = 16,
    parameter int unsigned TASK_ID_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // APB configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [csfw_pkg::PADDR_W-1:0]        paddr,
    input  logic [csfw_pkg::PDATA_W-1:0]        pwdata,
    output logic [csfw_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    // Input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          func,
    input  logic [TASK_ID_BITS-1:0]             task_id,
    // Output channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [3:0]                          status,
    output logic                                wake_valid,
    output logic [TASK_ID_BITS-1:0]             wake_task,
    output logic [csfw_pkg::COUNT_W-1:0]        count_now,
    output logic [$clog2(MAX_WAITERS+1)-1:0]    waiters_now
);

    import csfw_pkg::*;

    localparam int unsigned IDX_W  = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int unsigned FILL_W = $clog2(MAX_WAITERS + 1);

    logic [COUNT_W-1:0]      max_count_reg;
    logic                    cfg_write;
    logic                    step;
    csfw_result_t            result;
    logic [FILL_W-1:0]       waiters_next;
    logic                    mem_wr_en;
    logic [IDX_W-1:0]        mem_wr_idx;
    logic [TASK_ID_BITS-1:0] mem_wr_data;
    logic                    mem_rd_en;
    logic [IDX_W-1:0]        mem_rd_idx;
    logic [TASK_ID_BITS-1:0] mem_rd_data;
    logic                    out_valid_reg;
    csfw_result_t            result_reg;
    logic [FILL_W-1:0]       waiters_reg;

    // Configuration register at address 0; being the only register, it takes
    // every write, and reads of other addresses return zero.
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign prdata    = (paddr == '0) ? PDATA_W'(max_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_count_reg <= COUNT_W'(1);
        end
        else if (cfg_write)
        begin
            max_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // A word is taken when the output register is empty or being emptied.
    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    csfw_ctrl #(
        .MAX_WAITERS  (MAX_WAITERS),
        .TASK_ID_BITS (TASK_ID_BITS),
        .IDX_W        (IDX_W),
        .FILL_W       (FILL_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .func         (func),
        .task_id      (task_id),
        .max_count    (max_count_reg),
        .result       (result),
        .waiters_next (waiters_next),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_idx   (mem_wr_idx),
        .mem_wr_data  (mem_wr_data),
        .mem_rd_en    (mem_rd_en),
        .mem_rd_idx   (mem_rd_idx)
    );

    csfw_queue_mem #(
        .DEPTH (MAX_WAITERS),
        .WIDTH (TASK_ID_BITS),
        .IDX_W (IDX_W)
    ) u_queue_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_idx  (mem_wr_idx),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_idx  (mem_rd_idx),
        .rd_data (mem_rd_data)
    );

    // Output register; the woken task number comes from the memory read register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg  <= result;
            waiters_reg <= waiters_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = result_reg.status;
    assign wake_valid  = result_reg.wake_valid;
    assign wake_task   = result_reg.wake_valid ? mem_rd_data : '0;
    assign count_now   = result_reg.count_now;
    assign waiters_now = waiters_reg;

`ifndef ASSERT_OFF
    // A new word is never taken over a result that is still stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        step |-> !(out_valid && !out_ready))
        else $error("input taken while result stalled");

    // A woken task is reported only with the hand-over status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && wake_valid) |-> (status == ST_HANDED))
        else $error("wake without hand-over");

    // The queue never reports more waiters than it can hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (waiters_now <= FILL_W'(MAX_WAITERS)))
        else $error("waiter count beyond queue depth");

    // A queued task always leaves at least one waiter behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_QUEUED) |-> (waiters_now != '0))
        else $error("queued with empty queue");
`endif

endmodule

/* rtl/csfw_queue_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csfw_queue_mem
// Wait queue storage: one write port and one read port, with the read data
// registered.
// ----------------------------------------------------------------------------
module csfw_queue_mem #(
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned WIDTH  = 8,
    parameter int unsigned IDX_W  = 4
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_idx,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Entries hold no reset value; an entry is only read after it was written.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/csfw_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csfw_ctrl
// Semaphore control: holds the unit count and the queue pointers, decides
// the outcome of each operation and issues the queue memory accesses.
// ----------------------------------------------------------------------------
module csfw_ctrl #(
    parameter int unsigned MAX_WAITERS  = 16,
    parameter int unsigned TASK_ID_BITS = 8,
    parameter int unsigned IDX_W        = 4,
    parameter int unsigned FILL_W       = 5
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 step,
    input  logic [1:0]                           func,
    input  logic [TASK_ID_BITS-1:0]              task_id,
    input  logic [csfw_pkg::COUNT_W-1:0]         max_count,
    output csfw_pkg::csfw_result_t               result,
    output logic [FILL_W-1:0]                    waiters_next,
    output logic                                 mem_wr_en,
    output logic [IDX_W-1:0]                     mem_wr_idx,
    output logic [TASK_ID_BITS-1:0]              mem_wr_data,
    output logic                                 mem_rd_en,
    output logic [IDX_W-1:0]                     mem_rd_idx
);

    import csfw_pkg::*;

    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(MAX_WAITERS - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(MAX_WAITERS);

    logic [COUNT_W-1:0] held_reg, held_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [IDX_W-1:0]   tail_reg, tail_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               unit_free;
    logic               wr_req;
    logic               rd_req;

    assign unit_free = (held_reg < max_count);

    // Decide the outcome and the next count and pointer values.
    always_comb
    begin
        held_next         = held_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        fill_next         = fill_reg;
        wr_req            = 1'b0;
        rd_req            = 1'b0;
        result.status     = ST_ACQUIRED;
        result.wake_valid = 1'b0;
        case (func)
            FN_TRY:
            begin
                if (unit_free)
                begin
                    held_next     = held_reg + COUNT_W'(1);
                    result.status = ST_ACQUIRED;
                end
                else
                begin
                    result.status = ST_REFUSED;
                end
            end
            FN_WAIT:
            begin
                if (unit_free)
                begin
                    held_next     = held_reg + COUNT_W'(1);
                    result.status = ST_ACQUIRED;
                end
                else if (fill_reg == FULL_FILL)
                begin
                    result.status = ST_QFULL;
                end
                else
                begin
                    wr_req        = 1'b1;
                    tail_next     = (tail_reg == LAST_IDX) ? '0 : tail_reg + IDX_W'(1);
                    fill_next     = fill_reg + FILL_W'(1);
                    result.status = ST_QUEUED;
                end
            end
            FN_RELEASE:
            begin
                if (fill_reg != '0)
                begin
                    // Hand the unit to the oldest waiter; its number is read here.
                    rd_req            = 1'b1;
                    head_next         = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
                    fill_next         = fill_reg - FILL_W'(1);
                    result.wake_valid = 1'b1;
                    result.status     = ST_HANDED;
                end
                else if (held_reg != '0)
                begin
                    held_next     = held_reg - COUNT_W'(1);
                    result.status = ST_RELEASED;
                end
                else
                begin
                    result.status = ST_UNDERFLOW;
                end
            end
            default:
            begin
                // Check whether every unit is held.
                result.status = unit_free ? ST_CHECK_FAIL : ST_CHECK_OK;
            end
        endcase
        result.count_now = held_next;
    end

    assign waiters_next = fill_next;
    assign mem_wr_en    = step & wr_req;
    assign mem_wr_idx   = tail_reg;
    assign mem_wr_data  = task_id;
    assign mem_rd_en    = step & rd_req;
    assign mem_rd_idx   = head_reg;

    // Count and pointer registers advance once per accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else if (step)
        begin
            held_reg <= held_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

endmodule

/* sim/tb_counting_semaphore_fifo_waiters.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_counting_semaphore_fifo_waiters
// Self-checking bench for the counting semaphore with its FIFO wait queue.
// A directed sequence walks through underflow, refusal, queueing, hand-over,
// a zero limit and a limit raised while tasks wait. It is followed by random
// phases under several max_count settings, and most phases lean toward one
// kind of operation so the queue fills, overflows and drains. Every result
// word is compared field by field with a cycle-free copy of the semaphore
// kept in the bench.
// ----------------------------------------------------------------------------
module tb_counting_semaphore_fifo_waiters;
    import csfw_pkg::*;

    localparam int unsigned QUEUE_DEPTH    = 16;
    localparam int unsigned TASK_BITS      = 8;
    localparam int unsigned WAIT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned RESET_CYCLES   = 8;
    localparam int unsigned DRAIN_SLACK    = 4;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned REG_MAX_COUNT  = 0;

    // One request word and the outcome it should produce.
    typedef struct {
        logic [1:0]           fn;
        logic [TASK_BITS-1:0] tid;
    } sem_req_t;

    typedef struct {
        status_t              status;
        logic                 wake;
        logic [TASK_BITS-1:0] wake_task;
        logic [COUNT_W-1:0]   count;
        logic [WAIT_W-1:0]    waiters;
    } sem_outcome_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [PADDR_W-1:0]         paddr = '0;
    logic [PDATA_W-1:0]         pwdata = '0;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [1:0]                 func = FN_TRY;
    logic [TASK_BITS-1:0]       task_id = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [3:0]                 status;
    logic                       wake_valid;
    logic [TASK_BITS-1:0]       wake_task;
    logic [COUNT_W-1:0]         count_now;
    logic [WAIT_W-1:0]          waiters_now;

    // Bench copy of the semaphore state and its limit.
    logic [COUNT_W-1:0]         unit_limit = 8'd1;
    logic [COUNT_W-1:0]         units_held = '0;
    logic [TASK_BITS-1:0]       waiting_tasks[$];

    sem_req_t                   request_words[$];
    sem_outcome_t               pending_outcomes[$];
    sem_req_t                   next_req;
    sem_outcome_t               oldest;

    int unsigned                tx_idle_max = 0;
    int unsigned                rx_idle_max = 0;
    int unsigned                send_gap = 0;
    int unsigned                recv_stall = 0;
    int unsigned                rx_draw;
    int unsigned                quiet_cycles = 0;
    int unsigned                mismatches = 0;

    counting_semaphore_fifo_waiters #(
        .MAX_WAITERS  (QUEUE_DEPTH),
        .TASK_ID_BITS (TASK_BITS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .task_id     (task_id),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .wake_valid  (wake_valid),
        .wake_task   (wake_task),
        .count_now   (count_now),
        .waiters_now (waiters_now)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Apply one operation to the bench copy and return the word it should give.
    function automatic sem_outcome_t apply_sem_op(logic [1:0] fn, logic [TASK_BITS-1:0] tid);
        sem_outcome_t r;
        r.status    = ST_ACQUIRED;
        r.wake      = 1'b0;
        r.wake_task = '0;
        case (fn)
            FN_TRY:
            begin
                if (units_held < unit_limit)
                begin
                    units_held++;
                    r.status = ST_ACQUIRED;
                end
                else
                begin
                    r.status = ST_REFUSED;
                end
            end
            FN_WAIT:
            begin
                if (units_held < unit_limit)
                begin
                    units_held++;
                    r.status = ST_ACQUIRED;
                end
                else if (waiting_tasks.size() >= QUEUE_DEPTH)
                begin
                    r.status = ST_QFULL;
                end
                else
                begin
                    waiting_tasks.push_back(tid);
                    r.status = ST_QUEUED;
                end
            end
            FN_RELEASE:
            begin
                if (waiting_tasks.size() != 0)
                begin
                    r.wake      = 1'b1;
                    r.wake_task = waiting_tasks.pop_front();
                    r.status    = ST_HANDED;
                end
                else if (units_held != 0)
                begin
                    units_held--;
                    r.status = ST_RELEASED;
                end
                else
                begin
                    r.status = ST_UNDERFLOW;
                end
            end
            default:
            begin
                r.status = (units_held < unit_limit) ? ST_CHECK_FAIL : ST_CHECK_OK;
            end
        endcase
        r.count   = units_held;
        r.waiters = WAIT_W'(waiting_tasks.size());
        return r;
    endfunction

    task automatic report(string msg);
        $display("[%0t] %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic compare_field(string name, int got, int want);
        if (got != want)
            report($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
    endtask

    // Register write: setup cycle, then access cycle; pready is always high.
    task automatic apb_write(int unsigned index, logic [PDATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(index * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == REG_MAX_COUNT)
            unit_limit = value[COUNT_W-1:0];
    endtask

    task automatic queue_op(logic [1:0] fn, logic [TASK_BITS-1:0] tid);
        sem_req_t r;
        r.fn  = fn;
        r.tid = tid;
        request_words.push_back(r);
    endtask

    // Hold off until every word is sent and every result has come back.
    // The falling edge is used so that the clocked blocks have settled.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (request_words.size() != 0 || in_valid || pending_outcomes.size() != 0);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    // One random phase: set the limit while idle, then queue weighted operations.
    task automatic run_phase(logic [COUNT_W-1:0] limit, int unsigned n,
                             int unsigned w_try, int unsigned w_wait,
                             int unsigned w_rel, int unsigned w_chk,
                             int unsigned txi, int unsigned rxi);
        int unsigned total;
        int unsigned pick;
        logic [1:0]  fn;
        total = w_try + w_wait + w_rel + w_chk;
        wait_drained();
        apb_write(REG_MAX_COUNT, PDATA_W'(limit));
        tx_idle_max = txi;
        rx_idle_max = rxi;
        repeat (n)
        begin
            pick = $urandom_range(0, total - 1);
            if (pick < w_try)
                fn = FN_TRY;
            else if (pick < w_try + w_wait)
                fn = FN_WAIT;
            else if (pick < w_try + w_wait + w_rel)
                fn = FN_RELEASE;
            else
                fn = FN_CHECK;
            queue_op(fn, TASK_BITS'($urandom_range(0, 255)));
        end
    endtask

    // Sender: present the next word after a random gap, hold it until taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (send_gap != 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (request_words.size() != 0)
            begin
                next_req = request_words.pop_front();
                func     <= next_req.fn;
                task_id  <= next_req.tid;
                in_valid <= 1'b1;
                send_gap <= $urandom_range(0, tx_idle_max);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: after each result word, stall for a random number of cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            recv_stall <= 0;
        end
        else if (out_valid && out_ready)
        begin
            rx_draw = $urandom_range(0, rx_idle_max);
            out_ready  <= (rx_draw == 0);
            recv_stall <= rx_draw;
        end
        else if (recv_stall != 0)
        begin
            recv_stall <= recv_stall - 1;
            out_ready  <= (recv_stall == 1);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Monitor: check each result word, then record the outcome of each new request.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    report($sformatf("result word with nothing pending, status %0d", status));
                end
                else
                begin
                    oldest = pending_outcomes.pop_front();
                    compare_field("status", status, oldest.status);
                    compare_field("wake_valid", wake_valid, oldest.wake);
                    compare_field("wake_task", wake_task, oldest.wake_task);
                    compare_field("count_now", count_now, oldest.count);
                    compare_field("waiters_now", waiters_now, oldest.waiters);
                end
            end
            if (in_valid && in_ready)
                pending_outcomes.push_back(apply_sem_op(func, task_id));
        end
    end

    // Watchdog: cycles in a row with no word moving on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        tx_idle_max = 14;
        rx_idle_max = 14;

        // Limit 1 from reset: underflow, check both ways, refusal, queueing
        // and hand-over in arrival order, then release back to zero.
        queue_op(FN_RELEASE, 8'h00);
        queue_op(FN_CHECK,   8'hFF);
        queue_op(FN_TRY,     8'h00);
        queue_op(FN_CHECK,   8'h00);
        queue_op(FN_TRY,     8'hFF);
        queue_op(FN_WAIT,    8'hFF);
        queue_op(FN_WAIT,    8'h00);
        queue_op(FN_WAIT,    8'hA5);
        queue_op(FN_RELEASE, 8'h5A);
        queue_op(FN_RELEASE, 8'h00);
        queue_op(FN_RELEASE, 8'h00);
        queue_op(FN_RELEASE, 8'h00);
        queue_op(FN_WAIT,    8'h5A);
        queue_op(FN_RELEASE, 8'h00);
        wait_drained();

        // A zero limit: no unit is ever free, so waits queue and a check passes.
        apb_write(REG_MAX_COUNT, 0);
        queue_op(FN_TRY,     8'h01);
        queue_op(FN_WAIT,    8'h3C);
        queue_op(FN_WAIT,    8'hC3);
        queue_op(FN_CHECK,   8'h80);
        wait_drained();

        // Limit raised while tasks wait: acquires bypass the queue.
        apb_write(REG_MAX_COUNT, 2);
        queue_op(FN_TRY,     8'h7F);
        queue_op(FN_WAIT,    8'h11);
        queue_op(FN_WAIT,    8'h22);
        queue_op(FN_CHECK,   8'hFE);
        repeat (5) queue_op(FN_RELEASE, 8'h00);

        // Random phases. Wait-heavy phases overflow the queue, release-heavy
        // ones drain it; the first 255 phase saturates the count before the limit
        // is lowered far below it.
        run_phase(8'd1,   100, 1, 6, 2, 1, 14, 14);
        run_phase(8'd1,   100, 1, 1, 6, 1,  0,  0);
        run_phase(8'd255, 300, 6, 6, 0, 1,  0, 14);
        run_phase(8'd3,    80, 1, 1, 6, 2, 14,  0);
        run_phase(8'($urandom_range(1, 8)), 120, 2, 3, 3, 1, 14, 14);
        run_phase(8'd0,    60, 2, 3, 1, 1,  0,  0);
        run_phase(8'd255,  80, 2, 2, 3, 1, 14,  0);
        run_phase(8'($urandom_range(1, 255)), 100, 1, 1, 1, 1, 0, 14);
        run_phase(8'd2,   100, 1, 4, 4, 1, 14, 14);
        wait_drained();

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* counting_semaphore_fifo_waiters.f */
rtl/csfw_pkg.sv
rtl/csfw_queue_mem.sv
rtl/csfw_ctrl.sv
rtl/counting_semaphore_fifo_waiters.sv
sim/tb_counting_semaphore_fifo_waiters.sv
